// ===== hw/rtl/wals_pkg.sv =====
// types, constants and helpers shared by the anti-aliased line stepper
package wals_pkg;

    localparam int COORD_W    = 6;
    localparam int COORD_MAX  = 63;
    localparam int FRAC_BITS  = 16;
    localparam int WEIGHT_W   = 8;
    localparam int PART_W     = COORD_W + 1;
    localparam int SLOPE_W    = FRAC_BITS + 2;
    localparam int POS_W      = FRAC_BITS + COORD_W + 2;
    localparam int DIV_STEPS  = COORD_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COORD_W-1:0]  COORD_LIMIT  = COORD_W'(COORD_MAX);
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = WEIGHT_W'(255);

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  main_x;
        logic [COORD_W-1:0]  main_y;
        logic [WEIGHT_W-1:0] main_weight;
        logic                has_partner;
        logic [PART_W-1:0]   partner_x;
        logic [PART_W-1:0]   partner_y;
        logic [WEIGHT_W-1:0] partner_weight;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic                      sloped;
        logic                      xmajor;
        logic [COORD_W-1:0]        maj_start;
        logic [COORD_W-1:0]        maj_end;
        logic [COORD_W-1:0]        min_start;
        logic [COORD_W-1:0]        min_end;
        logic signed [SLOPE_W-1:0] slope;
    } line_cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_LIMIT) ? COORD_LIMIT : v;
    endfunction

endpackage

// ===== hw/rtl/wals_queue.sv =====
// small command queue between the line setup and the pixel stepper
module wals_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  wals_pkg::line_cmd_t  push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output wals_pkg::line_cmd_t  pop_data
);

    wals_pkg::line_cmd_t                   entry_reg [wals_pkg::QUEUE_DEPTH];
    logic [wals_pkg::QPTR_W-1:0]           wr_ptr_reg;
    logic [wals_pkg::QPTR_W-1:0]           rd_ptr_reg;
    logic [wals_pkg::QCNT_W-1:0]           count_reg;
    logic                                  do_push;
    logic                                  do_pop;

    assign push_ready = (count_reg != wals_pkg::QCNT_W'(wals_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/wals_front.sv =====
// line setup: accepts a line, orders its endpoints and forms the slope by long division
module wals_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wals_pkg::in_item_t   s_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output wals_pkg::line_cmd_t  push_data
);

    localparam int DW = wals_pkg::COORD_W;

    wals_pkg::front_state_t             state_reg;
    wals_pkg::front_state_t             state_next;
    wals_pkg::line_cmd_t                cmd_reg;
    wals_pkg::line_cmd_t                cmd_next;
    logic [DW-1:0]                      dmaj_reg;
    logic                               neg_reg;
    logic [DW-1:0]                      rem_reg;
    logic [wals_pkg::DIV_STEPS-1:0]     div_reg;
    logic [wals_pkg::DIV_CNT_W-1:0]     cnt_reg;

    logic [DW-1:0] x0, y0, x1, y1;
    logic [DW-1:0] adx, ady, a0, a1, m0, m1;
    logic          xmajor, swap, neg;
    logic [DW-1:0] absmin;
    logic          accept;
    logic          div_last;
    logic [DW:0]   trial;
    logic          take;
    logic [DW-1:0] rem_step;
    logic [wals_pkg::DIV_STEPS-1:0] div_step;
    logic [wals_pkg::SLOPE_W-1:0]   quo;
    logic signed [wals_pkg::SLOPE_W-1:0] slope_val;

    assign accept   = s_valid && s_ready;
    assign div_last = (cnt_reg == wals_pkg::DIV_CNT_W'(wals_pkg::DIV_STEPS - 1));

    // setup classification
    always_comb begin
        x0     = wals_pkg::sat_coord(s_data.start_x);
        y0     = wals_pkg::sat_coord(s_data.start_y);
        x1     = wals_pkg::sat_coord(s_data.end_x);
        y1     = wals_pkg::sat_coord(s_data.end_y);
        adx    = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady    = (y1 > y0) ? y1 - y0 : y0 - y1;
        xmajor = (ady < adx);
        swap   = xmajor ? (x1 < x0) : (y1 < y0);
        a0     = xmajor ? (swap ? x1 : x0) : (swap ? y1 : y0);
        a1     = xmajor ? (swap ? x0 : x1) : (swap ? y0 : y1);
        m0     = xmajor ? (swap ? y1 : y0) : (swap ? x1 : x0);
        m1     = xmajor ? (swap ? y0 : y1) : (swap ? x0 : x1);
        neg    = (m1 < m0);
        absmin = neg ? m0 - m1 : m1 - m0;

        cmd_next.slope = '0;
        if (x0 == x1) begin
            cmd_next.sloped    = 1'b0;
            cmd_next.xmajor    = 1'b0;
            cmd_next.maj_start = (y1 < y0) ? y1 : y0;
            cmd_next.maj_end   = (y1 < y0) ? y0 : y1;
            cmd_next.min_start = x0;
            cmd_next.min_end   = x0;
        end else if (y0 == y1) begin
            cmd_next.sloped    = 1'b0;
            cmd_next.xmajor    = 1'b1;
            cmd_next.maj_start = (x1 < x0) ? x1 : x0;
            cmd_next.maj_end   = (x1 < x0) ? x0 : x1;
            cmd_next.min_start = y0;
            cmd_next.min_end   = y0;
        end else begin
            cmd_next.sloped    = 1'b1;
            cmd_next.xmajor    = xmajor;
            cmd_next.maj_start = a0;
            cmd_next.maj_end   = a1;
            cmd_next.min_start = m0;
            cmd_next.min_end   = m1;
        end
    end

    // one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, div_reg[wals_pkg::DIV_STEPS-1]};
        take      = (trial >= {1'b0, dmaj_reg});
        rem_step  = take ? DW'(trial - {1'b0, dmaj_reg}) : trial[DW-1:0];
        div_step  = {div_reg[wals_pkg::DIV_STEPS-2:0], take};
        quo       = div_step[wals_pkg::SLOPE_W-1:0];
        slope_val = neg_reg ? -$signed(quo) : $signed(quo);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wals_pkg::F_IDLE: begin
                if (accept) begin
                    state_next = cmd_next.sloped ? wals_pkg::F_DIV : wals_pkg::F_PUSH;
                end
            end
            wals_pkg::F_DIV: begin
                if (div_last) begin
                    state_next = wals_pkg::F_PUSH;
                end
            end
            wals_pkg::F_PUSH: begin
                if (push_ready) begin
                    state_next = wals_pkg::F_IDLE;
                end
            end
            default: state_next = wals_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == wals_pkg::F_IDLE);
        push_valid = (state_reg == wals_pkg::F_PUSH);
        push_data  = cmd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wals_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_next;
            dmaj_reg <= a1 - a0;
            neg_reg  <= neg;
            rem_reg  <= '0;
            div_reg  <= {absmin, {wals_pkg::FRAC_BITS{1'b0}}};
            cnt_reg  <= '0;
        end else if (state_reg == wals_pkg::F_DIV) begin
            rem_reg <= rem_step;
            div_reg <= div_step;
            cnt_reg <= cnt_reg + 1'b1;
            if (div_last) begin
                cmd_reg.slope <= slope_val;
            end
        end
    end

endmodule

// ===== hw/rtl/wals_back.sv =====
// pixel stepper: walks the major axis and emits full-weight single-pixel beats and pixel-pair beats
module wals_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  wals_pkg::line_cmd_t  pop_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wals_pkg::out_item_t  m_data
);

    localparam int FB = wals_pkg::FRAC_BITS;
    localparam int CW = wals_pkg::COORD_W;
    localparam int WW = wals_pkg::WEIGHT_W;
    localparam int PW = wals_pkg::POS_W;

    wals_pkg::back_state_t          state_reg;
    wals_pkg::back_state_t          state_next;
    wals_pkg::line_cmd_t            cmd_reg;
    logic [CW-1:0]                  i_reg;
    logic signed [PW-1:0]           pos_reg;
    logic                           out_valid_reg;
    wals_pkg::out_item_t            out_reg;

    logic                           slot_free;
    logic                           emit;
    logic                           is_start;
    logic                           is_end;
    logic                           interior;
    logic [FB-1:0]                  frac;
    logic [FB:0]                    one_minus_f;
    logic [FB+WW:0]                 wm_full;
    logic [FB+WW:0]                 wp_full;
    logic [CW-1:0]                  fl_main;
    logic [wals_pkg::PART_W-1:0]    fl_part;
    logic [CW-1:0]                  minor;
    logic signed [PW-1:0]           slope_ext;
    logic signed [PW-1:0]           pos_load;
    wals_pkg::out_item_t            beat;

    assign slot_free = !out_valid_reg || m_ready;
    assign emit      = (state_reg == wals_pkg::B_RUN) && slot_free;
    assign is_start  = (i_reg == cmd_reg.maj_start);
    assign is_end    = (i_reg == cmd_reg.maj_end);
    assign interior  = cmd_reg.sloped && !is_start && !is_end;

    assign slope_ext = PW'(pop_data.slope);
    assign pos_load  = $signed({2'b00, pop_data.min_start, {FB{1'b0}}}) + slope_ext;

    // weights and neighbor from the fixed-point minor position
    always_comb begin
        frac        = pos_reg[FB-1:0];
        one_minus_f = {1'b1, {FB{1'b0}}} - {1'b0, frac};
        wm_full     = {one_minus_f, {WW{1'b0}}} - {{WW{1'b0}}, one_minus_f};
        wp_full     = {1'b0, frac, {WW{1'b0}}} - {{(WW+1){1'b0}}, frac};
        fl_main     = pos_reg[FB+CW-1:FB];
        fl_part     = pos_reg[FB+CW:FB] + 1'b1;

        if (!cmd_reg.sloped || is_start) begin
            minor = cmd_reg.min_start;
        end else if (is_end) begin
            minor = cmd_reg.min_end;
        end else begin
            minor = fl_main;
        end

        beat.main_x         = cmd_reg.xmajor ? i_reg : minor;
        beat.main_y         = cmd_reg.xmajor ? minor : i_reg;
        beat.main_weight    = interior ? wm_full[FB+WW-1:FB] : wals_pkg::WEIGHT_FULL;
        beat.has_partner    = interior;
        beat.partner_x      = '0;
        beat.partner_y      = '0;
        beat.partner_weight = '0;
        if (interior) begin
            beat.partner_x      = cmd_reg.xmajor ? {1'b0, i_reg} : fl_part;
            beat.partner_y      = cmd_reg.xmajor ? fl_part : {1'b0, i_reg};
            beat.partner_weight = wp_full[FB+WW-1:FB];
        end
        beat.last = is_end;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wals_pkg::B_IDLE: begin
                if (pop_valid) begin
                    state_next = wals_pkg::B_RUN;
                end
            end
            wals_pkg::B_RUN: begin
                if (emit && is_end) begin
                    state_next = wals_pkg::B_IDLE;
                end
            end
            default: state_next = wals_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        pop_ready = (state_reg == wals_pkg::B_IDLE);
        m_valid   = out_valid_reg;
        m_data    = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wals_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            cmd_reg <= pop_data;
            i_reg   <= pop_data.maj_start;
            pos_reg <= pos_load;
        end else if (emit) begin
            i_reg <= i_reg + 1'b1;
            if (interior) begin
                pos_reg <= pos_reg + PW'(cmd_reg.slope);
            end
        end
        if (emit) begin
            out_reg <= beat;
        end
    end

endmodule

// ===== hw/rtl/wu_antialiased_line_stepper_unit.sv =====
// anti-aliased line stepper top level: line setup, command queue and pixel stepper
// setup of a sloped line also runs the long divider, an axis-parallel line skips it
// the stepper emits one beat per cycle while the output is not stalled
// the setup can take a new line while the stepper works, with up to 4 lines queued between the parts
// reset clears the handshake and queue state only, no clearing pass
module wu_antialiased_line_stepper_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wals_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wals_pkg::out_item_t  m_data
);

    logic                 push_valid;
    logic                 push_ready;
    wals_pkg::line_cmd_t  push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    wals_pkg::line_cmd_t  pop_data;

    wals_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    wals_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wals_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
